// File: design/crfd_pkg.sv
// crfd_pkg: shared types, codes and constants of the reply frequency decoder.
// Used by every module of the block. Depends on nothing.

package crfd_pkg;

    // Frame limits
    localparam int unsigned MAX_REPLY_LEN   = 255;
    localparam int unsigned MAX_AFFIX_BYTES = 8;
    localparam int unsigned MAX_DATA_SIZE   = 16;

    // Word widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned RES_W   = 16;
    localparam int unsigned RANGE_W = 48;
    localparam int unsigned PROD_W  = ACC_W + RES_W;
    localparam int unsigned DIGIT_W = 9;
    localparam int unsigned REM_W   = 7;
    localparam int unsigned CNT_W   = 7;

    // Decoding constants
    localparam logic [3:0]         NIBBLE_MASK   = 4'hF;
    localparam logic [DIGIT_W-1:0] BCD_TEN       = 9'd10;
    localparam logic [DIGIT_W-1:0] ASCII_ZERO    = 9'd48;
    localparam logic [REM_W:0]     SCALE_DIVISOR = 8'd100;

    // Division by 100: long division in 16-bit digits, each digit's quotient
    // taken by reciprocal multiplication (exact for remainder:digit < 100*2^16)
    localparam int unsigned DIV_DIGIT_W = 16;
    localparam int unsigned DIV_STEPS   = PROD_W / DIV_DIGIT_W;
    localparam int unsigned DIV_NUM_W   = REM_W + DIV_DIGIT_W;
    localparam int unsigned RECIP_W     = 24;
    localparam int unsigned RECIP_SHIFT = 30;
    localparam int unsigned DIV_PROD_W  = DIV_NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;  // ceil(2^30 / 100)

    // Command queue depth
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DATA_FORMAT   = 3'd0,
        CFG_DATA_SIZE     = 3'd1,
        CFG_PREFIX_BYTES  = 3'd2,
        CFG_POSTFIX_BYTES = 3'd3,
        CFG_FRAME_LAYOUT  = 3'd4,
        CFG_RESOLUTION    = 3'd5,
        CFG_MIN_VALUE     = 3'd6,
        CFG_MAX_VALUE     = 3'd7
    } cfg_index_t;

    // data_format codes
    localparam logic [2:0] FMT_BCD     = 3'd0;
    localparam logic [2:0] FMT_BIN     = 3'd1;
    localparam logic [2:0] FMT_DEC     = 3'd2;
    localparam logic [2:0] FMT_BCD_REV = 3'd3;
    localparam logic [2:0] FMT_BIN_REV = 3'd4;
    localparam logic [2:0] FMT_DEC_REV = 3'd5;

    typedef enum logic [1:0] {
        KIND_BCD = 2'd0,
        KIND_BIN = 2'd1,
        KIND_DEC = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_PREFIX  = 3'd1,
        ST_POSTFIX = 3'd2,
        ST_LENGTH  = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]         data_format;
        logic [4:0]         data_size;
        logic [63:0]        prefix_bytes;
        logic [63:0]        postfix_bytes;
        logic [23:0]        frame_layout;
        logic [RES_W-1:0]   resolution;
        logic [RANGE_W-1:0] min_value;
        logic [RANGE_W-1:0] max_value;
    } cfg_t;

    // One queued command: a data byte to fold in, a frame end, or both.
    // At a frame end, ST_OK means the range check is still to be done.
    typedef struct packed {
        logic               do_mac;
        logic               do_end;
        logic [DIGIT_W-1:0] digit;
        kind_t              kind;
        logic               reversed;
        logic               known;
        status_t            status;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MAC_MUL,
        BK_MAC_ADD,
        BK_SCALE_MUL,
        BK_SCALE_DIV,
        BK_FINISH
    } back_state_t;

endpackage

// File: design/crfd_front.sv
// crfd_front: takes reply bytes, tracks frame position and affix matches,
// and issues data and frame-end commands. Depends on crfd_pkg.

module crfd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  crfd_pkg::cfg_t      cfg,
    input  logic                push,
    input  logic [7:0]          reply_byte,
    input  logic                last_byte,
    input  logic                cmd_full,
    output logic                cmd_push,
    output crfd_pkg::cmd_t      cmd
);

    logic [crfd_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                         prefix_ok_reg, prefix_ok_next;
    logic                         postfix_ok_reg, postfix_ok_next;
    logic                         overlong_reg, overlong_next;

    logic                         accept;
    logic                         known, reversed;
    crfd_pkg::kind_t              kind;
    logic [4:0]                   size_sat, dlen;
    logic [3:0]                   plen, qlen;
    logic [crfd_pkg::POS_W-1:0]   dstart, dend, qstart, qend, rlen, post_off;
    logic                         in_data;
    logic [crfd_pkg::DIGIT_W-1:0] digit;

    assign accept = push && !cmd_full;

    // Format decode
    always_comb
    begin
        known    = 1'b1;
        reversed = 1'b0;
        kind     = crfd_pkg::KIND_BIN;
        unique case (cfg.data_format) inside
            crfd_pkg::FMT_BCD, crfd_pkg::FMT_BCD_REV:
            begin
                kind = crfd_pkg::KIND_BCD;
            end
            crfd_pkg::FMT_BIN, crfd_pkg::FMT_BIN_REV:
            begin
                kind = crfd_pkg::KIND_BIN;
            end
            crfd_pkg::FMT_DEC, crfd_pkg::FMT_DEC_REV:
            begin
                kind = crfd_pkg::KIND_DEC;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
        if (cfg.data_format == crfd_pkg::FMT_BCD_REV || cfg.data_format == crfd_pkg::FMT_BIN_REV
            || cfg.data_format == crfd_pkg::FMT_DEC_REV)
        begin
            reversed = 1'b1;
        end
    end

    // Frame layout
    always_comb
    begin
        size_sat = (cfg.data_size > 5'(crfd_pkg::MAX_DATA_SIZE))
                   ? 5'(crfd_pkg::MAX_DATA_SIZE) : cfg.data_size;
        dlen     = (kind == crfd_pkg::KIND_BCD) ? 5'((6'(size_sat) + 6'd1) >> 1) : size_sat;
        plen     = (cfg.frame_layout[3:0] > 4'(crfd_pkg::MAX_AFFIX_BYTES))
                   ? 4'(crfd_pkg::MAX_AFFIX_BYTES) : cfg.frame_layout[3:0];
        qlen     = (cfg.frame_layout[15:12] > 4'(crfd_pkg::MAX_AFFIX_BYTES))
                   ? 4'(crfd_pkg::MAX_AFFIX_BYTES) : cfg.frame_layout[15:12];
        dstart   = 8'(plen) + 8'(cfg.frame_layout[7:4]);
        dend     = dstart + 8'(dlen);
        qstart   = dend + 8'(cfg.frame_layout[11:8]);
        qend     = qstart + 8'(qlen);
        rlen     = cfg.frame_layout[23:16];
        post_off = pos_reg - qstart;
    end

    // Digit value of the byte; ascii may go negative (two's complement)
    always_comb
    begin
        case (kind)
            crfd_pkg::KIND_BCD:
                digit = 9'(reply_byte[7:4]) * crfd_pkg::BCD_TEN
                        + 9'(reply_byte[3:0] & crfd_pkg::NIBBLE_MASK);
            crfd_pkg::KIND_DEC:
                digit = {1'b0, reply_byte} - crfd_pkg::ASCII_ZERO;
            default:
                digit = {1'b0, reply_byte};
        endcase
    end

    always_comb
    begin
        pos_next        = pos_reg;
        prefix_ok_next  = prefix_ok_reg;
        postfix_ok_next = postfix_ok_reg;
        overlong_next   = overlong_reg;
        in_data         = 1'b0;

        if (pos_reg == 8'(crfd_pkg::MAX_REPLY_LEN))
        begin
            overlong_next = 1'b1;
        end
        else
        begin
            if (pos_reg < 8'(plen))
            begin
                if (cfg.prefix_bytes[8*pos_reg[2:0] +: 8] != reply_byte)
                    prefix_ok_next = 1'b0;
            end
            else if (pos_reg >= dstart && pos_reg < dend)
            begin
                in_data = 1'b1;
            end
            else if (pos_reg >= qstart && pos_reg < qend)
            begin
                if (cfg.postfix_bytes[8*post_off[2:0] +: 8] != reply_byte)
                    postfix_ok_next = 1'b0;
            end
            pos_next = pos_reg + 8'd1;
        end

        cmd.do_mac   = in_data && known;
        cmd.do_end   = last_byte;
        cmd.digit    = digit;
        cmd.kind     = kind;
        cmd.reversed = reversed;
        cmd.known    = known;
        if (overlong_next || pos_next != rlen)
            cmd.status = crfd_pkg::ST_LENGTH;
        else if (!prefix_ok_next || pos_next < 8'(plen))
            cmd.status = crfd_pkg::ST_PREFIX;
        else if (!postfix_ok_next || pos_next < qend)
            cmd.status = crfd_pkg::ST_POSTFIX;
        else
            cmd.status = crfd_pkg::ST_OK;

        cmd_push = accept && (cmd.do_mac || cmd.do_end);

        // frame state clears once the last byte is taken
        if (last_byte)
        begin
            pos_next        = '0;
            prefix_ok_next  = 1'b1;
            postfix_ok_next = 1'b1;
            overlong_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            prefix_ok_reg  <= 1'b1;
            postfix_ok_reg <= 1'b1;
            overlong_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            prefix_ok_reg  <= prefix_ok_next;
            postfix_ok_reg <= postfix_ok_next;
            overlong_reg   <= overlong_next;
        end
    end

endmodule

// File: design/crfd_cmdq.sv
// crfd_cmdq: short command queue between front and back ends.
// Depends on crfd_pkg.

module crfd_cmdq
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  crfd_pkg::cmd_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output crfd_pkg::cmd_t  rd_data,
    output logic            empty
);

    crfd_pkg::cmd_t                   mem_reg [crfd_pkg::CMDQ_DEPTH];
    logic [crfd_pkg::CMDQ_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [crfd_pkg::CMDQ_AW:0]       count_reg, count_next;
    logic                             do_wr, do_rd;

    assign full    = (count_reg == (crfd_pkg::CMDQ_AW + 1)'(crfd_pkg::CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// File: design/crfd_back.sv
// crfd_back: accumulates data digits, scales by resolution/100 with a
// shift-add multiplier and a 16-bit-digit reciprocal divider, range-checks,
// holds result. Depends on crfd_pkg.

module crfd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  crfd_pkg::cfg_t      cfg,
    input  logic                cmd_empty,
    input  crfd_pkg::cmd_t      cmd_in,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output logic [2:0]          status,
    output logic [47:0]         frequency
);

    localparam int unsigned AW = crfd_pkg::ACC_W;
    localparam int unsigned PW = crfd_pkg::PROD_W;

    crfd_pkg::back_state_t          state_reg, state_next;
    crfd_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [AW-1:0]                  acc_reg, acc_next;
    logic [AW-1:0]                  weight_reg, weight_next;
    logic [AW-1:0]                  prod_reg, prod_next;
    logic [PW-1:0]                  scale_reg, scale_next;
    logic [PW-1:0]                  mcand_reg, mcand_next;
    logic [crfd_pkg::RES_W-1:0]     mplier_reg, mplier_next;
    logic [crfd_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [crfd_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;
    crfd_pkg::status_t              out_status_reg, out_status_next;
    logic [crfd_pkg::RANGE_W-1:0]   out_freq_reg, out_freq_next;

    logic [AW-1:0]                  digit_ext;
    logic [AW-1:0]                  fval;
    logic [crfd_pkg::DIV_NUM_W-1:0]   div_num;
    logic [crfd_pkg::DIV_PROD_W-1:0]  div_prod;
    logic [crfd_pkg::DIV_DIGIT_W-1:0] div_q;
    logic [crfd_pkg::DIV_NUM_W-1:0]   div_qx100;
    logic                           in_range;

    function automatic logic [AW-1:0] mul_base(input logic [AW-1:0] x,
                                               input crfd_pkg::kind_t k);
        logic [AW-1:0] r;
        case (k)
            crfd_pkg::KIND_BCD: r = (x << 6) + (x << 5) + (x << 2);
            crfd_pkg::KIND_DEC: r = (x << 3) + (x << 1);
            default:            r = x << 8;
        endcase
        return r;
    endfunction

    assign digit_ext = {{(AW - crfd_pkg::DIGIT_W){cmd_reg.digit[crfd_pkg::DIGIT_W-1]}},
                        cmd_reg.digit};
    assign fval      = (|scale_reg[PW-1:AW]) ? '1 : scale_reg[AW-1:0];
    assign in_range  = (fval >= AW'(cfg.min_value)) && (fval <= AW'(cfg.max_value));

    // one quotient digit: (remainder:next digit) / 100 by reciprocal
    assign div_num   = {rem_reg, scale_reg[PW-1 -: crfd_pkg::DIV_DIGIT_W]};
    assign div_prod  = crfd_pkg::DIV_PROD_W'(div_num)
                       * crfd_pkg::DIV_PROD_W'(crfd_pkg::RECIP_100);
    assign div_q     = div_prod[crfd_pkg::RECIP_SHIFT +: crfd_pkg::DIV_DIGIT_W];
    assign div_qx100 = crfd_pkg::DIV_NUM_W'(div_q)
                       * crfd_pkg::DIV_NUM_W'(crfd_pkg::SCALE_DIVISOR);

    assign empty     = !out_valid_reg;
    assign status    = out_status_reg;
    assign frequency = out_freq_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        acc_next        = acc_reg;
        weight_next     = weight_reg;
        prod_next       = prod_reg;
        scale_next      = scale_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_status_next = out_status_reg;
        out_freq_next   = out_freq_reg;
        cmd_pop         = 1'b0;

        unique case (state_reg)
            crfd_pkg::BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_in;
                    if (cmd_in.do_mac)
                    begin
                        state_next = crfd_pkg::BK_MAC_MUL;
                    end
                    else if (cmd_in.status == crfd_pkg::ST_OK && cmd_in.known)
                    begin
                        mcand_next  = PW'(acc_reg);
                        mplier_next = cfg.resolution;
                        scale_next  = '0;
                        cnt_next    = '0;
                        state_next  = crfd_pkg::BK_SCALE_MUL;
                    end
                    else
                    begin
                        scale_next = '0;
                        state_next = crfd_pkg::BK_FINISH;
                    end
                end
            end

            crfd_pkg::BK_MAC_MUL:
            begin
                if (cmd_reg.reversed)
                begin
                    // digit is signed nine bits: low byte times weight, less 256*weight
                    prod_next   = AW'(weight_reg * cmd_reg.digit[7:0])
                                  - (cmd_reg.digit[8] ? (weight_reg << 8) : '0);
                    weight_next = mul_base(weight_reg, cmd_reg.kind);
                end
                else
                begin
                    prod_next = mul_base(acc_reg, cmd_reg.kind);
                end
                state_next = crfd_pkg::BK_MAC_ADD;
            end

            crfd_pkg::BK_MAC_ADD:
            begin
                if (cmd_reg.reversed)
                    acc_next = acc_reg + prod_reg;
                else
                    acc_next = prod_reg + digit_ext;
                if (!cmd_reg.do_end)
                begin
                    state_next = crfd_pkg::BK_IDLE;
                end
                else if (cmd_reg.status == crfd_pkg::ST_OK && cmd_reg.known)
                begin
                    mcand_next  = PW'(acc_next);
                    mplier_next = cfg.resolution;
                    scale_next  = '0;
                    cnt_next    = '0;
                    state_next  = crfd_pkg::BK_SCALE_MUL;
                end
                else
                begin
                    scale_next = '0;
                    state_next = crfd_pkg::BK_FINISH;
                end
            end

            crfd_pkg::BK_SCALE_MUL:
            begin
                if (mplier_reg[0])
                    scale_next = scale_reg + mcand_reg;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == crfd_pkg::CNT_W'(crfd_pkg::RES_W - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = crfd_pkg::BK_SCALE_DIV;
                end
            end

            crfd_pkg::BK_SCALE_DIV:
            begin
                // long division by 100, top digit first; quotient shifts into scale_reg
                rem_next   = crfd_pkg::REM_W'(div_num - div_qx100);
                scale_next = {scale_reg[PW-crfd_pkg::DIV_DIGIT_W-1:0], div_q};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == crfd_pkg::CNT_W'(crfd_pkg::DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = crfd_pkg::BK_FINISH;
                end
            end

            crfd_pkg::BK_FINISH:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_freq_next  = '0;
                    if (cmd_reg.status != crfd_pkg::ST_OK)
                    begin
                        out_status_next = cmd_reg.status;
                    end
                    else if (in_range)
                    begin
                        out_status_next = crfd_pkg::ST_OK;
                        out_freq_next   = fval[crfd_pkg::RANGE_W-1:0];
                    end
                    else
                    begin
                        out_status_next = crfd_pkg::ST_RANGE;
                    end
                    acc_next    = '0;
                    weight_next = AW'(1);
                    state_next  = crfd_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = crfd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crfd_pkg::BK_IDLE;
            acc_reg       <= '0;
            weight_reg    <= AW'(1);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            weight_reg    <= weight_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        prod_reg       <= prod_next;
        scale_reg      <= scale_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        rem_reg        <= rem_next;
        out_status_reg <= out_status_next;
        out_freq_reg   <= out_freq_next;
    end

endmodule

// File: design/cat_reply_frequency_decoder_core.sv
// cat_reply_frequency_decoder_core: top level of the reply frequency decoder.
// Depends on crfd_pkg, crfd_front, crfd_cmdq and crfd_back.
//
// Use:
//   Reply bytes enter on the push/full side, one word per byte, with
//   last_byte high on the final byte of a frame. One result word (status,
//   frequency) per frame leaves on the empty/pop side. Registers are written
//   through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
//   Write registers only while no frame is in flight.
// Timing:
//   One byte per cycle enters while the 4-entry command queue has room. The
//   back end runs a multiply state and an add state for a data-field byte,
//   none for other bytes. A frame end goes straight to the finish state
//   when a check fails; a passing frame first takes 16 multiply and 5 divide
//   steps. Scaling sets the frame rate, the per-byte multiply-accumulate the
//   byte rate.
// Reset:
//   rst_n clears frame state, queue and result register, and loads the
//   register defaults (bcd, 10 digits, resolution 100, full range).
// Stalls:
//   A waiting result holds in its output register; the back end waits at
//   the next frame end, while bytes keep entering until the queue fills.

module cat_reply_frequency_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  reply_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [47:0] frequency,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    crfd_pkg::cfg_t   cfg_reg;
    crfd_pkg::cmd_t   front_cmd, back_cmd;
    logic             front_push, q_full, q_empty, q_pop;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_format   <= crfd_pkg::FMT_BCD;
            cfg_reg.data_size     <= 5'd10;
            cfg_reg.prefix_bytes  <= '0;
            cfg_reg.postfix_bytes <= '0;
            cfg_reg.frame_layout  <= '0;
            cfg_reg.resolution    <= 16'd100;
            cfg_reg.min_value     <= '0;
            cfg_reg.max_value     <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (crfd_pkg::cfg_index_t'(cfg_index))
                crfd_pkg::CFG_DATA_FORMAT:   cfg_reg.data_format   <= cfg_data[2:0];
                crfd_pkg::CFG_DATA_SIZE:     cfg_reg.data_size     <= cfg_data[4:0];
                crfd_pkg::CFG_PREFIX_BYTES:  cfg_reg.prefix_bytes  <= cfg_data;
                crfd_pkg::CFG_POSTFIX_BYTES: cfg_reg.postfix_bytes <= cfg_data;
                crfd_pkg::CFG_FRAME_LAYOUT:  cfg_reg.frame_layout  <= cfg_data[23:0];
                crfd_pkg::CFG_RESOLUTION:    cfg_reg.resolution    <= cfg_data[15:0];
                crfd_pkg::CFG_MIN_VALUE:     cfg_reg.min_value     <= cfg_data[47:0];
                crfd_pkg::CFG_MAX_VALUE:     cfg_reg.max_value     <= cfg_data[47:0];
                default:                     cfg_reg.data_format   <= cfg_reg.data_format;
            endcase
        end
    end

    // Front end: byte position, affix compare, digit extraction
    crfd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .reply_byte (reply_byte),
        .last_byte  (last_byte),
        .cmd_full   (q_full),
        .cmd_push   (front_push),
        .cmd        (front_cmd)
    );

    // Command queue decouples byte intake from the serial back end
    crfd_cmdq u_cmdq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (back_cmd),
        .empty   (q_empty)
    );

    // Back end: accumulate, scale, range check, result register
    crfd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (q_empty),
        .cmd_in    (back_cmd),
        .cmd_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .status    (status),
        .frequency (frequency)
    );

endmodule

// File: design/crfd_checker.sv
// crfd_assertions: port-level checks on the reply frequency decoder, bound to
// the top level. Depends on crfd_pkg and the top level's ports.

module crfd_assertions
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  status,
    input logic [47:0] frequency
);

    // a shown result carries a defined status code
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= 3'(crfd_pkg::ST_RANGE)))
    else $error("result status code out of range");

    // any failing frame reports frequency zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != 3'(crfd_pkg::ST_OK)) |-> (frequency == 48'd0))
    else $error("non-zero frequency on failed frame");

    // a result not taken stays on offer
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
    else $error("result withdrawn before pop");

    // a result not taken holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(status) && $stable(frequency)))
    else $error("result changed while stalled");

endmodule

bind cat_reply_frequency_decoder_core crfd_assertions u_crfd_assertions
(
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .status    (status),
    .frequency (frequency)
);
